/* rtl/core/assert_macros.svh */
// Assertion helpers for the color map core.
// All checks are sampled on the rising edge of clk and are ignored while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check
`define CMAP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication check
`define CMAP_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

/* rtl/core/cmap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cmap_pkg;

	// value format
	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	// datapath widths
	localparam int SPAN_W = VALUE_WIDTH + 1;   // exact difference of two values
	localparam int QBITS  = 8;                 // color byte quotient bits
	localparam int KSTEPS = 2;                 // segment index bits
	localparam int NUM_W  = SPAN_W + QBITS;    // 255 * fraction numerator
	localparam int NSTG   = 1 + KSTEPS + 2 + QBITS + 1;

	// register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 1'b1;

	localparam logic [VALUE_WIDTH-1:0] RANGE_MIN_RST = '0;
	localparam logic [VALUE_WIDTH-1:0] RANGE_MAX_RST =
		VALUE_WIDTH'(64'd1 << FRAC_BITS);

	// fixed colors
	localparam logic [7:0] GOLD_R = 8'd245;
	localparam logic [7:0] GOLD_G = 8'd210;
	localparam logic [7:0] GOLD_B = 8'd90;
	localparam logic [7:0] GREY_V = 8'd130;
	localparam logic [7:0] CH_MAX = 8'd255;
	localparam logic [7:0] CH_MIN = 8'd0;

	typedef enum logic [2:0] {
		KIND_RAMP,
		KIND_GOLD,
		KIND_GREY,
		KIND_GREEN,
		KIND_BLUE,
		KIND_RED
	} cmap_kind_t;

	typedef struct packed {
		cmap_kind_t             kind;
		logic [SPAN_W-1:0]      span;
		logic [NUM_W-1:0]       num;   // partial remainder
		logic [NUM_W-1:0]       dvs;   // shifted divisor
		logic [1:0]             k;     // ramp segment
		logic [QBITS-1:0]       q;     // quotient bits
		logic                   full;  // fraction is exactly one
	} cmap_pipe_t;

endpackage
`default_nettype wire

/* rtl/core/cmap_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cmap_front import cmap_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic [VALUE_WIDTH-1:0] deviation,
	input  logic                   has_deviation,
	input  logic                   point_active,
	input  logic [VALUE_WIDTH-1:0] range_min,
	input  logic [VALUE_WIDTH-1:0] range_max,
	output cmap_pipe_t             front_s1
);

	logic [SPAN_W-1:0] d_x, lo_x, hi_x;
	logic [SPAN_W-1:0] span_d, rem_d, over_d;
	logic              inverted, below, above;
	cmap_pipe_t        nxt;

	// classify the point and form span and offset
	always_comb begin
		d_x    = {deviation[VALUE_WIDTH-1], deviation};
		lo_x   = {range_min[VALUE_WIDTH-1], range_min};
		hi_x   = {range_max[VALUE_WIDTH-1], range_max};
		span_d = hi_x - lo_x;
		rem_d  = d_x - lo_x;
		over_d = d_x - hi_x;

		inverted = span_d[SPAN_W-1] || (span_d == '0);
		below    = rem_d[SPAN_W-1] || (rem_d == '0);
		above    = !over_d[SPAN_W-1];

		nxt      = '0;
		nxt.span = span_d;
		nxt.num  = {{(NUM_W-SPAN_W-2){1'b0}}, rem_d, 2'b00};
		nxt.dvs  = {{(NUM_W-SPAN_W-1){1'b0}}, span_d, 1'b0};
		if (!point_active) begin
			nxt.kind = KIND_GREY;
		end else if (!has_deviation) begin
			nxt.kind = KIND_GOLD;
		end else if (inverted) begin
			nxt.kind = KIND_GREEN;
		end else if (below) begin
			nxt.kind = KIND_BLUE;
		end else if (above) begin
			nxt.kind = KIND_RED;
		end else begin
			nxt.kind = KIND_RAMP;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/cmap_div_step.sv */
`timescale 1ns / 1ps
`default_nettype none
module cmap_div_step import cmap_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  cmap_pipe_t pipe_in,
	output cmap_pipe_t step_s1
);

	cmap_pipe_t nxt;

	// one restoring division step, divisor halves each stage
	always_comb begin
		nxt = pipe_in;
		if (pipe_in.num >= pipe_in.dvs) begin
			nxt.num = pipe_in.num - pipe_in.dvs;
			nxt.q   = {pipe_in.q[QBITS-2:0], 1'b1};
		end else begin
			nxt.q   = {pipe_in.q[QBITS-2:0], 1'b0};
		end
		nxt.dvs = pipe_in.dvs >> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s1 <= nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/cmap_frac.sv */
`timescale 1ns / 1ps
`default_nettype none
module cmap_frac import cmap_pkg::*; (
	input  logic       clk,
	input  logic       en_sel,
	input  logic       en_mul,
	input  cmap_pipe_t pipe_in,
	output cmap_pipe_t sel_s1,
	output cmap_pipe_t mul_s2
);

	cmap_pipe_t        sel_nxt, mul_nxt;
	logic [SPAN_W-1:0] rem, x_sel, x_mul;

	// pick rising or falling fraction for the segment
	always_comb begin
		rem         = pipe_in.num[SPAN_W-1:0];
		x_sel       = pipe_in.q[0] ? (pipe_in.span - rem) : rem;
		sel_nxt     = pipe_in;
		sel_nxt.k   = pipe_in.q[1:0];
		sel_nxt.q   = '0;
		sel_nxt.full = pipe_in.q[0] && (rem == '0);
		sel_nxt.num = {{QBITS{1'b0}}, x_sel};
	end

	// numerator 255*x and divisor span<<7 for the byte quotient
	always_comb begin
		x_mul       = sel_s1.num[SPAN_W-1:0];
		mul_nxt     = sel_s1;
		mul_nxt.num = {x_mul, {QBITS{1'b0}}} - {{QBITS{1'b0}}, x_mul};
		mul_nxt.dvs = {1'b0, sel_s1.span, {(QBITS-1){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en_sel) begin
			sel_s1 <= sel_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en_mul) begin
			mul_s2 <= mul_nxt;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/cmap_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cmap_back import cmap_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  cmap_pipe_t pipe_in,
	output logic [7:0] red_s1,
	output logic [7:0] green_s1,
	output logic [7:0] blue_s1,
	output logic       used_s1
);

	logic [SPAN_W-1:0] rem;
	logic              rnd;
	logic [7:0]        v;
	logic [7:0]        r_n, g_n, b_n;
	logic              u_n;

	// round half up, then build the color
	always_comb begin
		rem = pipe_in.num[SPAN_W-1:0];
		rnd = {rem, 1'b0} >= {1'b0, pipe_in.span};
		if (pipe_in.full || (pipe_in.q == {QBITS{1'b1}})) begin
			v = CH_MAX;
		end else begin
			v = pipe_in.q + {7'd0, rnd};
		end

		r_n = CH_MIN;
		g_n = CH_MIN;
		b_n = CH_MIN;
		u_n = 1'b1;
		case (pipe_in.kind)
			KIND_GOLD: begin
				r_n = GOLD_R;
				g_n = GOLD_G;
				b_n = GOLD_B;
				u_n = 1'b0;
			end
			KIND_GREY: begin
				r_n = GREY_V;
				g_n = GREY_V;
				b_n = GREY_V;
				u_n = 1'b0;
			end
			KIND_GREEN: begin
				g_n = CH_MAX;
			end
			KIND_BLUE: begin
				b_n = CH_MAX;
			end
			KIND_RED: begin
				r_n = CH_MAX;
			end
			KIND_RAMP: begin
				case (pipe_in.k)
					2'd0: begin
						g_n = v;
						b_n = CH_MAX;
					end
					2'd1: begin
						g_n = CH_MAX;
						b_n = v;
					end
					2'd2: begin
						r_n = v;
						g_n = CH_MAX;
					end
					default: begin
						r_n = CH_MAX;
						g_n = v;
					end
				endcase
			end
			default: begin
				g_n = CH_MAX;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= r_n;
			green_s1 <= g_n;
			blue_s1  <= b_n;
			used_s1  <= u_n;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/deviation_contour_color_map.sv */
// Channel  | Signals                                   | Request moves when
// ---------+-------------------------------------------+--------------------------
// item     | item_valid/item_stall, deviation,          | item_valid && !item_stall
//          | has_deviation, point_active                |
// color    | color_valid/color_stall, red, green, blue, | color_valid && !color_stall
//          | contour_used                               |
// cfg      | cfg_valid/cfg_ready, cfg_index, cfg_data   | cfg_valid && cfg_ready
//
// One request per cycle while not stalled; stages: one classify stage, two segment divide
// steps, fraction select, multiply by 255, eight quotient steps, rounding/color stage.
// Each stage has its own valid bit and holds while the stage after it is full and blocked,
// so bubbles collapse and item_stall rises only when every stage is occupied.
// arst_n clears all valid bits and loads range_min = 0, range_max = 1.0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module deviation_contour_color_map import cmap_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic [VALUE_WIDTH-1:0] deviation,
	input  logic                   has_deviation,
	input  logic                   point_active,
	output logic                   color_valid,
	input  logic                   color_stall,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   contour_used,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [VALUE_WIDTH-1:0] cfg_data
);

	logic [VALUE_WIDTH-1:0] range_min_q, range_max_q;
	logic [NSTG-1:0]        vld_q;
	logic [NSTG:0]          rdy;
	cmap_pipe_t             pipe [NSTG-1];
	logic                   pipe_blocked, default_ok, ramp_ok;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= RANGE_MIN_RST;
			range_max_q <= RANGE_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RANGE_MIN: range_min_q <= cfg_data;
				CFG_RANGE_MAX: range_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage ready: a stage loads when empty or when its content moves on
	assign rdy[NSTG] = !color_stall;
	for (genvar i = 0; i < NSTG; i++) begin : g_rdy
		assign rdy[i] = !vld_q[i] || rdy[i+1];
	end

	assign item_stall  = !rdy[0];
	assign color_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= item_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// classify
	cmap_front u_front (
		.clk           (clk),
		.en            (rdy[0]),
		.deviation     (deviation),
		.has_deviation (has_deviation),
		.point_active  (point_active),
		.range_min     (range_min_q),
		.range_max     (range_max_q),
		.front_s1      (pipe[0])
	);

	// segment index, two quotient bits of 4*rem/span
	for (genvar i = 1; i <= KSTEPS; i++) begin : g_kstep
		cmap_div_step u_step (
			.clk     (clk),
			.en      (rdy[i]),
			.pipe_in (pipe[i-1]),
			.step_s1 (pipe[i])
		);
	end

	// fraction select and 255x numerator
	cmap_frac u_frac (
		.clk     (clk),
		.en_sel  (rdy[KSTEPS+1]),
		.en_mul  (rdy[KSTEPS+2]),
		.pipe_in (pipe[KSTEPS]),
		.sel_s1  (pipe[KSTEPS+1]),
		.mul_s2  (pipe[KSTEPS+2])
	);

	// color byte quotient, one bit per stage
	for (genvar i = KSTEPS + 3; i <= KSTEPS + 2 + QBITS; i++) begin : g_qstep
		cmap_div_step u_step (
			.clk     (clk),
			.en      (rdy[i]),
			.pipe_in (pipe[i-1]),
			.step_s1 (pipe[i])
		);
	end

	// rounding and output register
	cmap_back u_back (
		.clk      (clk),
		.en       (rdy[NSTG-1]),
		.pipe_in  (pipe[NSTG-2]),
		.red_s1   (red),
		.green_s1 (green),
		.blue_s1  (blue),
		.used_s1  (contour_used)
	);

	// terms for the checks below
	assign pipe_blocked = color_valid && color_stall && (&vld_q);
	assign default_ok   = (red == GOLD_R && green == GOLD_G && blue == GOLD_B)
		|| (red == GREY_V && green == GREY_V && blue == GREY_V);
	assign ramp_ok      = (red == CH_MAX || green == CH_MAX || blue == CH_MAX)
		&& (red == CH_MIN || green == CH_MIN || blue == CH_MIN);

	// input is held back only when the whole pipe is full behind a blocked output
	`CMAP_ASSERT_IMP(a_stall_full, item_stall, pipe_blocked, "input stalled with room in pipe")

	// contour_used low comes only with a default color
	`CMAP_ASSERT_IMP(a_default_color, color_valid && !contour_used, default_ok, "bad default color")

	// every ramp color has one channel at full and one at zero
	`CMAP_ASSERT(a_ramp_shape, !(color_valid && contour_used) || ramp_ok, "ramp color off the ramp")

endmodule
`default_nettype wire

/* tb/tb_deviation_contour_color_map.sv */
`timescale 1ns / 1ps
module tb_deviation_contour_color_map;
	import cmap_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 80;
	localparam int N_PHASES     = 10;
	localparam int PHASE_ITEMS  = 168;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       used;
	} rgb_t;

	localparam rgb_t GREY_C  = '{GREY_V, GREY_V, GREY_V, 1'b0};
	localparam rgb_t GOLD_C  = '{GOLD_R, GOLD_G, GOLD_B, 1'b0};
	localparam rgb_t BLUE_C  = '{CH_MIN, CH_MIN, CH_MAX, 1'b1};
	localparam rgb_t RED_C   = '{CH_MAX, CH_MIN, CH_MIN, 1'b1};
	localparam rgb_t GREEN_C = '{CH_MIN, CH_MAX, CH_MIN, 1'b1};
	localparam rgb_t NO_C    = '0;

	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

	// one directed row: a point request or a register write
	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [VALUE_WIDTH-1:0] val;
		logic                   has;
		logic                   act;
		bit                     known;
		rgb_t                   color;
	} row_t;

	localparam int N_ROWS = 28;
	localparam row_t ROWS [N_ROWS] = '{
		// default colors
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0000, 1'b1, 1'b0, 1'b1, GREY_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h7fff_ffff, 1'b0, 1'b1, 1'b1, GOLD_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h8000_0000, 1'b0, 1'b0, 1'b1, GREY_C},
		// extremes and range ends at reset range [0, 1.0]
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h8000_0000, 1'b1, 1'b1, 1'b1, BLUE_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1, RED_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0000, 1'b1, 1'b1, 1'b1, BLUE_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0001_0000, 1'b1, 1'b1, 1'b1, RED_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, BLUE_C},
		// segment starts and half-way points (round half up)
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_4000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_8000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_c000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_2000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_6000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_a000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_e000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0001, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_ffff, 1'b1, 1'b1, 1'b0, NO_C},
		// widest range
		'{ROW_CFG,  CFG_RANGE_MIN, 32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_C},
		'{ROW_CFG,  CFG_RANGE_MAX, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0000, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h8000_0001, 1'b1, 1'b1, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h7fff_fffe, 1'b1, 1'b1, 1'b0, NO_C},
		// empty range, then inverted range
		'{ROW_CFG,  CFG_RANGE_MAX, 32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h1234_5678, 1'b1, 1'b1, 1'b1, GREEN_C},
		'{ROW_CFG,  CFG_RANGE_MIN, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, NO_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h8000_0000, 1'b1, 1'b1, 1'b1, GREEN_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0000, 1'b0, 1'b1, 1'b1, GOLD_C},
		'{ROW_ITEM, CFG_RANGE_MIN, 32'h0000_0000, 1'b1, 1'b0, 1'b1, GREY_C}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_stall;
	logic [VALUE_WIDTH-1:0] deviation;
	logic                   has_deviation;
	logic                   point_active;
	logic                   color_valid;
	logic                   color_stall;
	logic [7:0]             red;
	logic [7:0]             green;
	logic [7:0]             blue;
	logic                   contour_used;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [VALUE_WIDTH-1:0] cfg_data;

	// local copy of the range registers
	logic [VALUE_WIDTH-1:0] cfg_min;
	logic [VALUE_WIDTH-1:0] cfg_max;

	// colors still owed by the block, oldest first
	rgb_t color_q [$];

	// expected color typed in by the directed table for the current request
	bit   fixed_known;
	rgb_t fixed_color;

	int errors;
	int cycles;
	int hold_req;

	deviation_contour_color_map u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.deviation    (deviation),
		.has_deviation(has_deviation),
		.point_active (point_active),
		.color_valid  (color_valid),
		.color_stall  (color_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.contour_used (contour_used),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// round_half_up(255 * x / span), saturating at a full fraction
	function automatic logic [7:0] ramp_byte(longint x, longint span);
		if (x >= span)
			return CH_MAX;
		return 8'((510 * x + span) / (2 * span));
	endfunction

	function automatic rgb_t predict_color(logic [VALUE_WIDTH-1:0] dev, logic has, logic act);
		rgb_t   c;
		longint lo, hi, d, span, frac, seg;
		if (!act || !has)
			return act ? GOLD_C : GREY_C;
		lo = longint'($signed(cfg_min));
		hi = longint'($signed(cfg_max));
		d  = longint'($signed(dev));
		if (hi <= lo)
			return GREEN_C;
		if (d <= lo)
			return BLUE_C;
		if (d >= hi)
			return RED_C;
		// 4*t split into segment and exact in-segment fraction frac/span
		span = hi - lo;
		frac = 4 * (d - lo);
		seg  = frac / span;
		frac = frac - seg * span;
		c = '{CH_MIN, CH_MIN, CH_MIN, 1'b1};
		case (seg)
			0: begin
				c.g = ramp_byte(frac, span);
				c.b = CH_MAX;
			end
			1: begin
				c.g = CH_MAX;
				c.b = ramp_byte(span - frac, span);
			end
			2: begin
				c.r = ramp_byte(frac, span);
				c.g = CH_MAX;
			end
			default: begin
				c.r = CH_MAX;
				c.g = ramp_byte(span - frac, span);
			end
		endcase
		return c;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
		end
	endtask

	// monitor: log accepted requests, compare accepted colors
	always @(posedge clk) begin
		rgb_t e;
		if (arst_n) begin
			if (item_valid && !item_stall)
				color_q.insert(color_q.size(), fixed_known ? fixed_color
					: predict_color(deviation, has_deviation, point_active));
			if (color_valid && !color_stall) begin
				if (color_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected color, actual %0d %0d %0d used %0d",
						$time, red, green, blue, contour_used);
				end else begin
					e = color_q.pop_front();
					check_field("red", e.r, red);
					check_field("green", e.g, green);
					check_field("blue", e.b, blue);
					check_field("contour_used", 8'(e.used), 8'(contour_used));
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout, %0d colors outstanding", $time, color_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// receiver back-pressure: random modes, plus long holds on request
	initial begin
		int mode, seg_left, hold_left, holds_done;
		color_stall = 1'b0;
		mode = 0;
		seg_left = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_done != hold_req) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				color_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(20, 150);
				end
				seg_left--;
				case (mode)
					0: color_stall <= 1'b0;
					1: color_stall <= ($urandom_range(0, 3) == 0);
					2: color_stall <= ($urandom_range(0, 9) < 7);
					default: color_stall <= (seg_left % 3 == 0);
				endcase
			end
		end
	end

	task automatic send_point(logic [VALUE_WIDTH-1:0] dev, logic has, logic act,
			bit known, rgb_t color);
		@(negedge clk);
		deviation     <= dev;
		has_deviation <= has;
		point_active  <= act;
		fixed_known   <= known;
		fixed_color   <= color;
		item_valid    <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
	endtask

	// sender gap with junk on the payload, its length given by n
	task automatic idle_gap(int n);
		@(negedge clk);
		item_valid    <= 1'b0;
		deviation     <= $urandom;
		has_deviation <= $urandom_range(0, 1);
		point_active  <= $urandom_range(0, 1);
		repeat (n - 1) @(negedge clk);
	endtask

	// stop offering and wait until every owed color has come back
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (color_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_RANGE_MIN)
			cfg_min = val;
		else
			cfg_max = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// pick the range for one random phase
	task automatic set_range(int phase);
		logic [VALUE_WIDTH-1:0] lo, hi, t;
		lo = $urandom;
		hi = $urandom;
		case (phase)
			0, 9: begin
				lo = RANGE_MIN_RST;
				hi = RANGE_MAX_RST;
			end
			1: begin
				lo = 32'h8000_0000;
				hi = 32'h7fff_ffff;
			end
			2: hi = lo;
			3: begin
				lo = 32'h7fff_ffff;
				hi = 32'h8000_0000;
			end
			4, 8: begin
				if ($signed(lo) > $signed(32'h7fff_0000))
					lo = lo - 32'h0001_0000;
				hi = lo + (phase == 4 ? $urandom_range(1, 7) : $urandom_range(8, 4096));
			end
			6: begin
				if ($signed(lo) > $signed(hi)) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
			7: begin
				lo = 32'hfffb_0000;
				hi = 32'hffff_0000;
			end
			default: ;
		endcase
		write_reg(CFG_RANGE_MIN, lo);
		write_reg(CFG_RANGE_MAX, hi);
	endtask

	// deviation that mostly lands in or next to the current range
	function automatic logic [VALUE_WIDTH-1:0] next_deviation();
		longint            lo, hi;
		longint unsigned   u;
		int                pick;
		lo = longint'($signed(cfg_min));
		hi = longint'($signed(cfg_max));
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return $urandom;
		if (pick < 20) begin
			case ($urandom_range(0, 5))
				0: return VALUE_WIDTH'(lo);
				1: return VALUE_WIDTH'(lo + 1);
				2: return VALUE_WIDTH'(lo - 1);
				3: return VALUE_WIDTH'(hi);
				4: return VALUE_WIDTH'(hi - 1);
				default: return VALUE_WIDTH'(hi + 1);
			endcase
		end
		if (hi > lo) begin
			u = {$urandom, $urandom};
			return VALUE_WIDTH'(lo + longint'(u % longint'(hi - lo + 1)));
		end
		return VALUE_WIDTH'(lo + longint'($urandom_range(0, 64)) - 32);
	endfunction

	initial begin
		int   burst_left;
		logic has, act;
		errors        = 0;
		cycles        = 0;
		hold_req      = 0;
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		deviation     = '0;
		has_deviation = 1'b0;
		point_active  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_RANGE_MIN;
		cfg_data      = '0;
		fixed_known   = 1'b0;
		fixed_color   = NO_C;
		cfg_min       = RANGE_MIN_RST;
		cfg_max       = RANGE_MAX_RST;
		burst_left    = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < N_ROWS; i++) begin
			if (ROWS[i].kind == ROW_CFG) begin
				wait_idle();
				write_reg(ROWS[i].idx, ROWS[i].val);
			end else begin
				send_point(ROWS[i].val, ROWS[i].has, ROWS[i].act, ROWS[i].known,
					ROWS[i].color);
			end
		end

		// random phases, each under a range set by set_range
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			set_range(p);
			// long receiver hold while the sender keeps going
			if (p == 1 || p == 5)
				hold_req++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					idle_gap($urandom_range(1, 8));
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				if ($urandom_range(0, 9) < 8) begin
					has = 1'b1;
					act = 1'b1;
				end else begin
					has = $urandom_range(0, 1);
					act = $urandom_range(0, 1);
				end
				send_point(next_deviation(), has, act, 1'b0, NO_C);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/cmap_pkg.sv
rtl/core/cmap_front.sv
rtl/core/cmap_div_step.sv
rtl/core/cmap_frac.sv
rtl/core/cmap_back.sv
rtl/core/deviation_contour_color_map.sv
tb/tb_deviation_contour_color_map.sv
